### sv/ilist_pkg.sv
// Package with the operation codes and the command bundle shared by the list modules.
`timescale 1ns / 1ps

package ilist_pkg;

    // Width of one list entry and of the index and count fields.
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int MODE_W  = 3;

    // Default number of cells in the row.
    localparam int DEFAULT_DEPTH = 16;

    // Operation codes carried by the mode field.
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_EDIT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

    // Command broadcast from the controller to every cell; the enables are
    // already qualified by the range and full checks.
    typedef struct packed {
        logic                     append;
        logic                     edit;
        logic                     insert;
        logic                     delete;
        logic [INDEX_W-1:0]       idx;
        logic signed [WORD_W-1:0] val;
    } cell_cmd_t;

endpackage

### sv/ilist_cell.sv
// One cell of the list: holds a single entry and trades it with its neighbors.
`timescale 1ns / 1ps

module ilist_cell
    import ilist_pkg::*;
#(
    parameter int POS = 0,
    parameter int CW  = 5
)
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic [CW-1:0]            filled,
    input  logic signed [WORD_W-1:0] left_q,
    input  logic signed [WORD_W-1:0] right_q,
    output logic signed [WORD_W-1:0] q
);

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;
    logic                     at_tail;
    logic                     at_idx;
    logic                     past_idx;

    // Position of this cell relative to the tail and to the operation index.
    assign at_tail  = (int'(filled) == POS);
    assign at_idx   = (int'(cmd.idx) == POS);
    assign past_idx = (int'(cmd.idx) < POS);

    // Pick the new content: new word, left neighbor on insert, right on delete.
    always_comb
    begin
        word_next = word_reg;
        if (cmd.append && at_tail)
        begin
            word_next = cmd.val;
        end
        else if (cmd.edit && at_idx)
        begin
            word_next = cmd.val;
        end
        else if (cmd.insert && at_idx)
        begin
            word_next = cmd.val;
        end
        else if (cmd.insert && past_idx)
        begin
            word_next = left_q;
        end
        else if (cmd.delete && (at_idx || past_idx))
        begin
            word_next = right_q;
        end
    end

    // Entry storage; contents are meaningful only below the fill count.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

### sv/ilist_ctrl.sv
// Controller of the list: decodes an item, keeps the fill count and registers the result.
`timescale 1ns / 1ps

module ilist_ctrl
    import ilist_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [MODE_W-1:0]        mode,
    input  logic [INDEX_W-1:0]       index,
    input  logic signed [WORD_W-1:0] value,
    input  logic signed [WORD_W-1:0] rd_word,
    output cell_cmd_t                cmd,
    output logic [CW-1:0]            filled,
    output logic                     done,
    output logic signed [WORD_W-1:0] read_value,
    output logic                     ok,
    output logic [COUNT_W-1:0]       entry_count
);

    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [CW-1:0]            filled_reg;
    logic [CW-1:0]            filled_next;
    logic                     done_reg;
    logic                     ok_reg;
    logic                     ok_next;
    logic signed [WORD_W-1:0] read_value_reg;
    logic signed [WORD_W-1:0] read_value_next;
    logic [COUNT_W-1:0]       entry_count_reg;
    logic                     in_range;
    logic                     full;

    // Range and capacity checks against the current fill count.
    assign in_range = (CMPW'(index) < CMPW'(filled_reg));
    assign full     = (filled_reg == CW'(DEPTH));

    // Decode the item into a qualified cell command and the next result.
    always_comb
    begin
        cmd             = '0;
        cmd.idx         = index;
        cmd.val         = value;
        filled_next     = filled_reg;
        ok_next         = 1'b0;
        read_value_next = '0;
        if (accept)
        begin
            case (mode)
                MODE_APPEND:
                begin
                    if (!full)
                    begin
                        cmd.append  = 1'b1;
                        filled_next = filled_reg + CW'(1);
                        ok_next     = 1'b1;
                    end
                end
                MODE_READ:
                begin
                    if (in_range)
                    begin
                        read_value_next = rd_word;
                        ok_next         = 1'b1;
                    end
                end
                MODE_EDIT:
                begin
                    if (in_range)
                    begin
                        cmd.edit = 1'b1;
                        ok_next  = 1'b1;
                    end
                end
                MODE_INSERT:
                begin
                    if (in_range && !full)
                    begin
                        cmd.insert  = 1'b1;
                        filled_next = filled_reg + CW'(1);
                        ok_next     = 1'b1;
                    end
                end
                MODE_DELETE:
                begin
                    if (in_range)
                    begin
                        cmd.delete  = 1'b1;
                        filled_next = filled_reg - CW'(1);
                        ok_next     = 1'b1;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // Fill count, result strobe, ok flag and entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg      <= '0;
            done_reg        <= 1'b0;
            ok_reg          <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            filled_reg <= filled_next;
            done_reg   <= accept;
            if (accept)
            begin
                ok_reg          <= ok_next;
                entry_count_reg <= COUNT_W'(filled_next);
            end
        end
    end

    // Result word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= read_value_next;
        end
    end

    assign filled      = filled_reg;
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;

endmodule

### sv/indexed_list_insert_delete_top.sv
// Top level of the bounded ordered list: controller plus a row of entry cells.
//
// Usage:
//   Command channel: an item (mode, index, value) is taken at a rising edge
//   where start is high and busy is low. busy stays low, so an item may be
//   issued in every cycle.
//   Result channel: one result per item. done is high for exactly one cycle,
//   the cycle after the item was taken, with read_value, ok and entry_count.
//   The receiver cannot stall; a result must be captured while done is high.
//   Throughput is 1 item per cycle. Insert and delete
//   move every later cell by one place in the same cycle, because each cell
//   loads from its left or right neighbor in parallel; the read path is a
//   mux over the first sixteen cells.
//   Reset (rst_n low) empties the list and clears done; cell contents are
//   left as they are and are only read after they have been written again.
//   An append or insert to a full list, a read, edit, insert or delete with an
//   index at or beyond the fill count, or an unknown mode: ok low, list unchanged.
`timescale 1ns / 1ps

module indexed_list_insert_delete_top
    import ilist_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [MODE_W-1:0]         mode,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [WORD_W-1:0]  value,
    output logic                      done,
    output logic signed [WORD_W-1:0]  read_value,
    output logic                      ok,
    output logic [COUNT_W-1:0]        entry_count
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int RD_N  = 1 << INDEX_W;

    logic                     accept;
    cell_cmd_t                cmd;
    logic [CW-1:0]            filled;
    logic signed [WORD_W-1:0] cell_q [DEPTH];
    logic signed [WORD_W-1:0] rd_arr [RD_N];
    logic signed [WORD_W-1:0] rd_word;

    // Every cycle can take a new item.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    ilist_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .index       (index),
        .value       (value),
        .rd_word     (rd_word),
        .cmd         (cmd),
        .filled      (filled),
        .done        (done),
        .read_value  (read_value),
        .ok          (ok),
        .entry_count (entry_count)
    );

    // Row of cells; each takes its neighbors' words for shifting.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = cell_q[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_q[i+1];
        end

        ilist_cell #(
            .POS (i),
            .CW  (CW)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .filled  (filled),
            .left_q  (left_w),
            .right_q (right_w),
            .q       (cell_q[i])
        );
    end

    // Read taps: only the cells an index can reach.
    for (genvar k = 0; k < RD_N; k++)
    begin : g_rd
        if (k < DEPTH)
        begin : g_tap
            assign rd_arr[k] = cell_q[k];
        end
        else
        begin : g_none
            assign rd_arr[k] = '0;
        end
    end

    assign rd_word = rd_arr[index];

    // Every accepted item gives a result strobe in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after an accepted item");

    // No strobe without an item taken in the cycle before.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result strobe without an accepted item");

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(entry_count) <= DEPTH))
        else $error("entry count beyond capacity");

    // A refused operation returns a zero word.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (read_value == '0))
        else $error("nonzero word on a refused operation");

endmodule
